[hdl/running_sample_statistics_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the running sample statistics unit.
// Each macro places one labeled concurrent assertion on the given clock,
// switched off while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef RUNNING_SAMPLE_STATISTICS_UNIT_DEFINES_SVH
`define RUNNING_SAMPLE_STATISTICS_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define RSS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rss: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define RSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rss: next-cycle check failed");

`endif

[hdl/rss_pkg.sv]
// ---------------------------------------------------------------------------
// rss_pkg
// Shared widths and status types of the running sample statistics unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    // Width of the running total and of the sum of squares.
    localparam int TOTAL_BITS = 56;
    localparam int SQSUM_BITS = 64;

    // Step counter width of the serial divider (one quotient bit a step).
    localparam int DIV_STEP_BITS = $clog2(SQSUM_BITS);

    // Status of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } rss_q_stat_t;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } rss_div_stat_t;

endpackage

`default_nettype wire

[hdl/rss_front.sv]
// ---------------------------------------------------------------------------
// rss_front
// Accepts samples, rejects negative ones, updates the running state and
// pushes a snapshot of the statistics state into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module rss_front #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 32,
    parameter int ENTRY_BITS  = 2 + COUNT_BITS + rss_pkg::TOTAL_BITS
                                + rss_pkg::SQSUM_BITS + 3 * SAMPLE_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS + 8) / 8) * 8-1:0] s_tdata,
    input  rss_pkg::rss_q_stat_t                  q_stat,
    output logic                                  q_push,
    output logic [ENTRY_BITS-1:0]                 q_entry
);
    import rss_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQR  = 2'd1;
    localparam logic [1:0] F_UPD  = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
    localparam logic [SQSUM_BITS-1:0] SQSUM_MAX = '1;

    logic [1:0]               state_reg, state_next;
    logic [SAMPLE_BITS-1:0]   x_reg;
    logic                     neg_reg;
    logic [2*SAMPLE_BITS-1:0] sq_reg;

    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [TOTAL_BITS-1:0]    total_reg, total_next;
    logic [SQSUM_BITS-1:0]    square_sum_reg, square_sum_next;
    logic [SAMPLE_BITS-1:0]   min_reg, min_next;
    logic [SAMPLE_BITS-1:0]   max_reg, max_next;
    logic [SAMPLE_BITS-1:0]   last_reg, last_next;
    logic                     flag_reg, flag_next;

    logic                     take;
    logic                     update;
    logic                     can_count;
    logic                     first;
    logic [TOTAL_BITS:0]      total_sum;
    logic [SQSUM_BITS:0]      square_sum;

    assign s_tready = (state_reg == F_IDLE);
    assign take     = s_tvalid && s_tready;
    assign update   = (state_reg == F_UPD) && !q_stat.full;
    assign q_push   = update;

    // Candidate sums, with a carry bit to detect saturation.
    assign can_count  = (count_reg != COUNT_MAX);
    assign first      = (count_reg == '0);
    assign total_sum  = {1'b0, total_reg} + (TOTAL_BITS + 1)'(x_reg);
    assign square_sum = {1'b0, square_sum_reg} + (SQSUM_BITS + 1)'(sq_reg);

    // Next statistics state for an accepted, non-negative sample.
    always_comb begin
        count_next      = count_reg;
        total_next      = total_reg;
        square_sum_next = square_sum_reg;
        flag_next       = flag_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        last_next       = last_reg;
        if (update && !neg_reg) begin
            if (can_count) begin
                count_next = count_reg + 1'b1;
                total_next = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
                if (square_sum[SQSUM_BITS]) begin
                    square_sum_next = SQSUM_MAX;
                    flag_next       = 1'b1;
                end else begin
                    square_sum_next = square_sum[SQSUM_BITS-1:0];
                end
            end
            if (first || (x_reg < min_reg)) begin
                min_next = x_reg;
            end
            if (first || (x_reg > max_reg)) begin
                max_next = x_reg;
            end
            last_next = x_reg;
        end
    end

    // Snapshot of the state after this item, accepted flag in the lowest bit.
    assign q_entry = {flag_next, last_next, max_next, min_next,
                      square_sum_next, total_next, count_next, !neg_reg};

    // Sequencer: take, square, update.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (take) begin
                    state_next = F_SQR;
                end
            end
            F_SQR: begin
                state_next = F_UPD;
            end
            F_UPD: begin
                if (!q_stat.full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= F_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            square_sum_reg <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            last_reg       <= '0;
            flag_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            square_sum_reg <= square_sum_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            last_reg       <= last_next;
            flag_reg       <= flag_next;
        end
    end

    // Sample capture and squaring, no reset needed.
    always_ff @(posedge aclk) begin
        if (take) begin
            x_reg   <= s_tdata[SAMPLE_BITS-1:0];
            neg_reg <= s_tdata[SAMPLE_BITS];
        end
        if (state_reg == F_SQR) begin
            sq_reg <= {{SAMPLE_BITS{1'b0}}, x_reg} * {{SAMPLE_BITS{1'b0}}, x_reg};
        end
    end

endmodule

`default_nettype wire

[hdl/rss_queue.sv]
// ---------------------------------------------------------------------------
// rss_queue
// Small register queue that decouples the front from the back.
// ---------------------------------------------------------------------------
`default_nettype none

module rss_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [WIDTH-1:0]     push_data,
    input  logic                 pop,
    output logic [WIDTH-1:0]     head_data,
    output rss_pkg::rss_q_stat_t stat
);
    import rss_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg, fill_next;

    assign stat.full  = (fill_reg == CNT_FULL);
    assign stat.empty = (fill_reg == '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    // Fill level follows pushes and pops.
    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/rss_div.sv]
// ---------------------------------------------------------------------------
// rss_div
// Serial restoring divider with two lanes that share one divisor: the
// running total and the sum of squares are divided by the count together,
// one quotient bit per lane in each cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rss_div #(
    parameter int DIVISOR_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [DIVISOR_BITS-1:0]             divisor,
    input  logic [rss_pkg::SQSUM_BITS-1:0]      dividend_a,
    input  logic [rss_pkg::SQSUM_BITS-1:0]      dividend_b,
    output logic [rss_pkg::SQSUM_BITS-1:0]      quot_a,
    output logic [rss_pkg::SQSUM_BITS-1:0]      quot_b,
    output rss_pkg::rss_div_stat_t              stat
);
    import rss_pkg::*;

    localparam logic [DIV_STEP_BITS-1:0] STEP_LAST = DIV_STEP_BITS'(SQSUM_BITS - 1);

    logic                     run_reg;
    logic                     done_reg;
    logic [DIV_STEP_BITS-1:0] step_reg;
    logic [DIVISOR_BITS-1:0]  den_reg;
    logic [SQSUM_BITS-1:0]    dvd_a_reg, dvd_b_reg;
    logic [DIVISOR_BITS-1:0]  rem_a_reg, rem_b_reg;

    logic [DIVISOR_BITS:0]    trial_a, trial_b;
    logic [DIVISOR_BITS:0]    diff_a, diff_b;
    logic                     ge_a, ge_b;

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign quot_a    = dvd_a_reg;
    assign quot_b    = dvd_b_reg;

    // One restoring step per lane: shift in the next dividend bit, subtract if it fits.
    assign trial_a = {rem_a_reg, dvd_a_reg[SQSUM_BITS-1]};
    assign trial_b = {rem_b_reg, dvd_b_reg[SQSUM_BITS-1]};
    assign diff_a  = trial_a - {1'b0, den_reg};
    assign diff_b  = trial_b - {1'b0, den_reg};
    assign ge_a    = (trial_a >= {1'b0, den_reg});
    assign ge_b    = (trial_b >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end else if (run_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_LAST) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend registers collect the quotient bits from the right.
    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg   <= divisor;
            dvd_a_reg <= dividend_a;
            dvd_b_reg <= dividend_b;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end else if (run_reg) begin
            dvd_a_reg <= {dvd_a_reg[SQSUM_BITS-2:0], ge_a};
            dvd_b_reg <= {dvd_b_reg[SQSUM_BITS-2:0], ge_b};
            rem_a_reg <= ge_a ? diff_a[DIVISOR_BITS-1:0] : trial_a[DIVISOR_BITS-1:0];
            rem_b_reg <= ge_b ? diff_b[DIVISOR_BITS-1:0] : trial_b[DIVISOR_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

[hdl/rss_back.sv]
// ---------------------------------------------------------------------------
// rss_back
// Takes state snapshots from the queue, derives mean and deviation with the
// serial divider and a serial square root, and holds the result in the
// output register until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module rss_back #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 32,
    parameter int ENTRY_BITS  = 2 + COUNT_BITS + rss_pkg::TOTAL_BITS
                                + rss_pkg::SQSUM_BITS + 3 * SAMPLE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rss_pkg::rss_q_stat_t               q_stat,
    input  logic [ENTRY_BITS-1:0]              q_entry,
    output logic                               q_pop,
    output logic                               div_start,
    output logic [COUNT_BITS-1:0]              div_divisor,
    output logic [rss_pkg::SQSUM_BITS-1:0]     div_dividend_a,
    output logic [rss_pkg::SQSUM_BITS-1:0]     div_dividend_b,
    input  logic [rss_pkg::SQSUM_BITS-1:0]     div_quot_a,
    input  logic [rss_pkg::SQSUM_BITS-1:0]     div_quot_b,
    input  rss_pkg::rss_div_stat_t             div_stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((COUNT_BITS + rss_pkg::TOTAL_BITS + 5 * SAMPLE_BITS + 7) / 8) * 8-1:0]
                                               m_tdata,
    output logic [1:0]                         m_tuser
);
    import rss_pkg::*;

    // Snapshot layout, lowest bit first.
    localparam int OFF_CNT  = 1;
    localparam int OFF_TOT  = OFF_CNT + COUNT_BITS;
    localparam int OFF_SQ   = OFF_TOT + TOTAL_BITS;
    localparam int OFF_MIN  = OFF_SQ + SQSUM_BITS;
    localparam int OFF_MAX  = OFF_MIN + SAMPLE_BITS;
    localparam int OFF_LAST = OFF_MAX + SAMPLE_BITS;
    localparam int OFF_FLAG = OFF_LAST + SAMPLE_BITS;

    localparam int FIELD_BITS = COUNT_BITS + TOTAL_BITS + 5 * SAMPLE_BITS;
    localparam int DATA_BITS  = ((FIELD_BITS + 7) / 8) * 8;

    localparam logic [SQSUM_BITS-1:0] SAMPLE_MASK = (SQSUM_BITS'(1) << SAMPLE_BITS) - 1'b1;
    localparam logic [SQSUM_BITS-1:0] SQRT_TOP    = SQSUM_BITS'(1) << (SQSUM_BITS - 2);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DIV  = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_DIFF = 3'd3;
    localparam logic [2:0] B_SQRT = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    logic [2:0]               state_reg, state_next;

    // Fields held from the snapshot.
    logic                     acc_reg;
    logic [COUNT_BITS-1:0]    cnt_reg;
    logic [TOTAL_BITS-1:0]    tot_reg;
    logic [SAMPLE_BITS-1:0]   min_reg, max_reg, last_reg;
    logic                     flag_reg;

    // Mean and deviation datapath.
    logic [SAMPLE_BITS-1:0]   mean_reg;
    logic [SAMPLE_BITS-1:0]   dev_reg;
    logic [SQSUM_BITS-1:0]    msq_reg;
    logic [2*SAMPLE_BITS-1:0] m2_reg;
    logic [SQSUM_BITS-1:0]    rad_reg, root_reg, bit_reg;

    // Output register.
    logic                     m_tvalid_reg;
    logic [DATA_BITS-1:0]     m_tdata_reg;
    logic [1:0]               m_tuser_reg;

    logic                     entry_zero;
    logic                     out_load;
    logic [SQSUM_BITS-1:0]    sqrt_trial;
    logic                     sqrt_fits;
    logic [SQSUM_BITS-1:0]    root_step;
    logic [SQSUM_BITS-1:0]    m2_wide;

    assign entry_zero = (q_entry[OFF_TOT-1:OFF_CNT] == '0);
    assign q_pop      = (state_reg == B_IDLE) && !q_stat.empty;
    assign out_load   = (state_reg == B_OUT) && (!m_tvalid_reg || m_tready);

    // The divider starts straight from the queue head.
    assign div_start      = q_pop && !entry_zero;
    assign div_divisor    = q_entry[OFF_TOT-1:OFF_CNT];
    assign div_dividend_a = SQSUM_BITS'(q_entry[OFF_SQ-1:OFF_TOT]);
    assign div_dividend_b = q_entry[OFF_MIN-1:OFF_SQ];

    // One step of the digit-by-digit square root.
    assign sqrt_trial = root_reg + bit_reg;
    assign sqrt_fits  = (rad_reg >= sqrt_trial);
    assign root_step  = sqrt_fits ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
    assign m2_wide    = SQSUM_BITS'(m2_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    state_next = entry_zero ? B_OUT : B_DIV;
                end
            end
            B_DIV: begin
                if (div_stat.done) begin
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                state_next = B_DIFF;
            end
            B_DIFF: begin
                state_next = (msq_reg > m2_wide) ? B_SQRT : B_OUT;
            end
            B_SQRT: begin
                if (bit_reg[0]) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (out_load) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    acc_reg  <= q_entry[0];
                    cnt_reg  <= q_entry[OFF_TOT-1:OFF_CNT];
                    tot_reg  <= q_entry[OFF_SQ-1:OFF_TOT];
                    min_reg  <= q_entry[OFF_MAX-1:OFF_MIN];
                    max_reg  <= q_entry[OFF_LAST-1:OFF_MAX];
                    last_reg <= q_entry[OFF_FLAG-1:OFF_LAST];
                    flag_reg <= q_entry[OFF_FLAG];
                    mean_reg <= '0;
                    dev_reg  <= '0;
                end
            end
            B_DIV: begin
                if (div_stat.done) begin
                    mean_reg <= (div_quot_a > SAMPLE_MASK) ? '1 : div_quot_a[SAMPLE_BITS-1:0];
                    msq_reg  <= div_quot_b;
                end
            end
            B_MUL: begin
                m2_reg <= {{SAMPLE_BITS{1'b0}}, mean_reg} * {{SAMPLE_BITS{1'b0}}, mean_reg};
            end
            B_DIFF: begin
                rad_reg  <= msq_reg - m2_wide;
                root_reg <= '0;
                bit_reg  <= SQRT_TOP;
            end
            B_SQRT: begin
                if (sqrt_fits) begin
                    rad_reg <= rad_reg - sqrt_trial;
                end
                root_reg <= root_step;
                bit_reg  <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    dev_reg <= (root_step > SAMPLE_MASK) ? '1 : root_step[SAMPLE_BITS-1:0];
                end
            end
            B_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= DATA_BITS'({last_reg, max_reg, min_reg, dev_reg,
                                               mean_reg, tot_reg, cnt_reg});
                    m_tuser_reg <= {flag_reg, acc_reg};
                end
            end
            default: begin
                mean_reg <= '0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[hdl/running_sample_statistics_unit.sv]
// ---------------------------------------------------------------------------
// running_sample_statistics_unit
// Running count, total, mean, deviation, minimum and maximum of samples.
// ---------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_ channel carries one two's complement duration
//   sample. A negative sample is rejected and leaves the statistics as they
//   were; every sample, rejected or not, yields exactly one transfer on the
//   m_ channel with the statistics after it.
//   The front takes a sample, squares it and updates the running state,
//   then hands a state snapshot to a two-entry queue.
//   The back works on one snapshot at a time: the shared two-lane serial
//   divider (total and sum of squares by the count), one multiply, one
//   subtract and 32 square-root steps. The square root is skipped when the
//   deviation is zero, and the whole computation while the count is zero.
//   The back takes no new snapshot before the last one is through, so the
//   back sets the sustained throughput.
//   Reset (aresetn low, synchronous) clears all statistics, the queue and
//   the output valid flag. When the receiver stalls, the result is held in
//   the output register, the back finishes its next item and waits, and
//   the front keeps taking samples until the queue is full.
// ---------------------------------------------------------------------------
`default_nettype none
`include "running_sample_statistics_unit_defines.svh"

module running_sample_statistics_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 32
) (
    input  logic aclk,
    input  logic aresetn,
    // s_tdata: sample (SAMPLE_BITS+1, signed).
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS + 8) / 8) * 8-1:0] s_tdata,
    // m_tdata: sample_count, running_total, mean_value, std_deviation,
    //          minimum_seen, maximum_seen, latest_sample.
    // m_tuser: accepted, squares_saturated.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((COUNT_BITS + rss_pkg::TOTAL_BITS + 5 * SAMPLE_BITS + 7) / 8) * 8-1:0]
                                                   m_tdata,
    output logic [1:0]                             m_tuser
);
    import rss_pkg::*;

    localparam int ENTRY_BITS  = 2 + COUNT_BITS + TOTAL_BITS + SQSUM_BITS + 3 * SAMPLE_BITS;
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_MEAN    = COUNT_BITS + TOTAL_BITS;

    rss_q_stat_t             q_stat;
    logic                    q_push;
    logic                    q_pop;
    logic [ENTRY_BITS-1:0]   q_push_data;
    logic [ENTRY_BITS-1:0]   q_head_data;

    rss_div_stat_t           div_stat;
    logic                    div_start;
    logic [COUNT_BITS-1:0]   div_divisor;
    logic [SQSUM_BITS-1:0]   div_dividend_a, div_dividend_b;
    logic [SQSUM_BITS-1:0]   div_quot_a, div_quot_b;

    // Front: sample intake and state update.
    rss_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (q_push_data)
    );

    // Snapshot queue between front and back.
    rss_queue #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head_data),
        .stat      (q_stat)
    );

    // Shared two-lane serial divider.
    rss_div #(
        .DIVISOR_BITS (COUNT_BITS)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .divisor    (div_divisor),
        .dividend_a (div_dividend_a),
        .dividend_b (div_dividend_b),
        .quot_a     (div_quot_a),
        .quot_b     (div_quot_b),
        .stat       (div_stat)
    );

    // Back: mean, deviation and output register.
    rss_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .ENTRY_BITS  (ENTRY_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .q_entry        (q_head_data),
        .q_pop          (q_pop),
        .div_start      (div_start),
        .div_divisor    (div_divisor),
        .div_dividend_a (div_dividend_a),
        .div_dividend_b (div_dividend_b),
        .div_quot_a     (div_quot_a),
        .div_quot_b     (div_quot_b),
        .div_stat       (div_stat),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

    // Checks on the queue, the divider hand-off and the zero-count result.
    `RSS_ASSERT_IMPL(a_queue_no_overflow, aclk, aresetn, q_stat.full, !q_push)
    `RSS_ASSERT_IMPL(a_queue_no_underflow, aclk, aresetn, q_stat.empty, !q_pop)
    `RSS_ASSERT_NEXT(a_div_runs_after_start, aclk, aresetn, div_start, div_stat.busy)
    `RSS_ASSERT_IMPL(a_zero_count_zero_mean, aclk, aresetn,
        m_tvalid && (m_tdata[COUNT_BITS-1:0] == '0),
        m_tdata[OUT_MEAN+2*SAMPLE_BITS-1:OUT_MEAN] == '0)

endmodule

`default_nettype wire
